// File: rtl/mepr_pkg.sv
// ----------------------------------------------------------------------------
// mepr_pkg
// Shared types and codes of the mesh edge pairing core.
// ----------------------------------------------------------------------------
package mepr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    EDGE_AB,
    EDGE_BC,
    EDGE_CA
  } edge_t;

  localparam logic KIND_PAIR     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  // Per-lane compare result of one table row.
  typedef struct packed {
    logic match;
    logic free;
  } lane_hit_t;

  // What the merge stage has found so far in the current scan.
  typedef struct packed {
    logic match_found;
    logic free_found;
  } find_t;

endpackage

// File: rtl/mepr_ifs.sv
// ----------------------------------------------------------------------------
// mepr channel interfaces
// Valid/ready channels for triangle requests and pairing results.
// ----------------------------------------------------------------------------
interface mepr_in_if #(
  parameter int VB = 16
);
  logic          valid;
  logic          ready;
  logic          first_triangle;
  logic [VB-1:0] corner_a;
  logic [VB-1:0] corner_b;
  logic [VB-1:0] corner_c;

  modport source (output valid, first_triangle, corner_a, corner_b, corner_c,
                  input ready);
  modport sink (input valid, first_triangle, corner_a, corner_b, corner_c,
                output ready);
endinterface

interface mepr_out_if #(
  parameter int VB = 16
);
  logic          valid;
  logic          ready;
  logic          kind;
  logic [VB-1:0] apex_first;
  logic [VB-1:0] apex_second;
  logic [VB-1:0] edge_start;
  logic [VB-1:0] edge_end;
  logic          last;

  modport source (output valid, kind, apex_first, apex_second, edge_start,
                  edge_end, last, input ready);
  modport sink (input valid, kind, apex_first, apex_second, edge_start,
                edge_end, last, output ready);
endinterface

// File: rtl/mepr_ram.sv
// ----------------------------------------------------------------------------
// mepr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mepr_ram #(
  parameter int W     = 49,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mepr_lane.sv
// ----------------------------------------------------------------------------
// mepr_lane
// One bank of the pending-edge table with its edge comparator.
// ----------------------------------------------------------------------------
module mepr_lane #(
  parameter int VB    = 16,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [3*VB:0]        wr_data,
  input  logic [VB-1:0]        q_start,
  input  logic [VB-1:0]        q_end,
  output mepr_pkg::lane_hit_t  hit,
  output logic [VB-1:0]        hit_start,
  output logic [VB-1:0]        hit_end,
  output logic [VB-1:0]        hit_apex
);

  logic [3*VB:0]       rdata;
  logic                ent_valid;
  logic [VB-1:0]       ent_start;
  logic [VB-1:0]       ent_end;
  mepr_pkg::lane_hit_t hit_nxt;
  mepr_pkg::lane_hit_t hit_r;
  logic [VB-1:0]       start_r;
  logic [VB-1:0]       end_r;
  logic [VB-1:0]       apex_r;

  mepr_ram #(
    .W     (3*VB + 1),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign ent_valid = rdata[3*VB];
  assign ent_start = rdata[3*VB-1:2*VB];
  assign ent_end   = rdata[2*VB-1:VB];

  // An edge matches in either direction.
  always_comb begin
    hit_nxt.match = ent_valid &&
                    (((ent_start == q_start) && (ent_end == q_end)) ||
                     ((ent_start == q_end) && (ent_end == q_start)));
    hit_nxt.free  = !ent_valid;
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    start_r <= ent_start;
    end_r   <= ent_end;
    apex_r  <= rdata[VB-1:0];
  end

  assign hit       = hit_r;
  assign hit_start = start_r;
  assign hit_end   = end_r;
  assign hit_apex  = apex_r;

endmodule

// File: rtl/mepr_merge.sv
// ----------------------------------------------------------------------------
// mepr_merge
// Combines the lane results of a scan into the lowest matching entry and
// the lowest free entry of the whole table.
// ----------------------------------------------------------------------------
module mepr_merge #(
  parameter int LANES = 8,
  parameter int VB    = 16,
  parameter int AW    = 5,
  parameter int LW    = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            en,
  input  logic [AW-1:0]                   row,
  input  mepr_pkg::lane_hit_t [LANES-1:0] hits,
  input  logic [LANES-1:0][VB-1:0]        lane_start,
  input  logic [LANES-1:0][VB-1:0]        lane_end,
  input  logic [LANES-1:0][VB-1:0]        lane_apex,
  output mepr_pkg::find_t                 find,
  output logic [LW-1:0]                   match_lane,
  output logic [AW-1:0]                   match_addr,
  output logic [VB-1:0]                   match_start,
  output logic [VB-1:0]                   match_end,
  output logic [VB-1:0]                   match_apex,
  output logic [LW-1:0]                   free_lane,
  output logic [AW-1:0]                   free_addr
);

  mepr_pkg::find_t find_r;
  logic            any_m;
  logic            any_f;
  logic [LW-1:0]   sel_m;
  logic [LW-1:0]   sel_f;
  logic [LW-1:0]   m_lane_r;
  logic [AW-1:0]   m_addr_r;
  logic [VB-1:0]   m_start_r;
  logic [VB-1:0]   m_end_r;
  logic [VB-1:0]   m_apex_r;
  logic [LW-1:0]   f_lane_r;
  logic [AW-1:0]   f_addr_r;

  // Entry index is row * LANES + lane, so within a row the lowest lane wins.
  always_comb begin
    any_m = 1'b0;
    any_f = 1'b0;
    sel_m = '0;
    sel_f = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hits[i].match) begin
        any_m = 1'b1;
        sel_m = LW'(i);
      end
      if (hits[i].free) begin
        any_f = 1'b1;
        sel_f = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      find_r <= '0;
    end else if (en) begin
      if (!find_r.match_found && any_m) begin
        find_r.match_found <= 1'b1;
      end
      if (!find_r.free_found && any_f) begin
        find_r.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !find_r.match_found && any_m) begin
      m_lane_r  <= sel_m;
      m_addr_r  <= row;
      m_start_r <= lane_start[sel_m];
      m_end_r   <= lane_end[sel_m];
      m_apex_r  <= lane_apex[sel_m];
    end
    if (en && !find_r.free_found && any_f) begin
      f_lane_r <= sel_f;
      f_addr_r <= row;
    end
  end

  assign find        = find_r;
  assign match_lane  = m_lane_r;
  assign match_addr  = m_addr_r;
  assign match_start = m_start_r;
  assign match_end   = m_end_r;
  assign match_apex  = m_apex_r;
  assign free_lane   = f_lane_r;
  assign free_addr   = f_addr_r;

endmodule

// File: rtl/mesh_edge_triangle_pairing_core.sv
// ----------------------------------------------------------------------------
// mesh_edge_triangle_pairing_core
// Pairs the edges of a triangle stream into dihedrals through a table of
// pending edges. The table is split into LANES banks of
// TABLE_DEPTH/LANES rows; entry row*LANES+lane lives in bank lane, and all
// lanes compare one row per cycle. Each edge is one full scan of the banks,
// a drain of the lane pipeline and a resolve step that frees the matching
// entry or stores the edge in a free one; after the last edge, CA, the final
// pending result is flushed before the next request is taken. The resolve of a
// new result and the flush wait while the pending slot is full and the output
// is stalled. A request with first_triangle set adds a clearing pass, and the
// same pass runs after reset before the first request is taken. Results come out on the
// result channel, one per edge that pairs or overflows, the final one of a triangle carrying last.
// TABLE_DEPTH must be a multiple of LANES.
// ----------------------------------------------------------------------------
module mesh_edge_triangle_pairing_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int VERTEX_BITS = 16,
  parameter int LANES       = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  mepr_in_if.sink           in_tri,
  mepr_out_if.source        out_res
);

  localparam int VB         = VERTEX_BITS;
  localparam int BANK_DEPTH = TABLE_DEPTH / LANES;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int WORD_W     = 3 * VB + 1;

  mepr_pkg::state_t state_r;
  mepr_pkg::state_t state_nxt;
  mepr_pkg::edge_t  edge_r;
  logic [BANK_AW-1:0] cnt_r;
  logic               clr_scan_r;
  logic [VB-1:0]      a_r;
  logic [VB-1:0]      b_r;
  logic [VB-1:0]      c_r;
  logic               rd_v_r;
  logic               cmp_v_r;
  logic [BANK_AW-1:0] rd_row_r;
  logic [BANK_AW-1:0] cmp_row_r;

  logic               pend_v_r;
  logic               pend_kind_r;
  logic [VB-1:0]      pend_ap1_r;
  logic [VB-1:0]      pend_ap2_r;
  logic [VB-1:0]      pend_s_r;
  logic [VB-1:0]      pend_e_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [VB-1:0]      out_ap1_r;
  logic [VB-1:0]      out_ap2_r;
  logic [VB-1:0]      out_s_r;
  logic [VB-1:0]      out_e_r;
  logic               out_last_r;

  logic               in_acc;
  logic               in_ready;
  logic               cnt_last;
  logic               out_free;
  logic               pipe_idle;
  logic               new_res;
  logic               res_go;
  logic               flush_go;
  logic               out_ld;
  logic               issue_v;
  logic               merge_clr;
  logic [LANES-1:0]   lane_we;
  logic [BANK_AW-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [VB-1:0]      q_s;
  logic [VB-1:0]      q_e;
  logic [VB-1:0]      q_apex;
  logic               res_kind;
  logic [VB-1:0]      res_ap1;
  logic [VB-1:0]      res_ap2;
  logic [VB-1:0]      res_s;
  logic [VB-1:0]      res_e;

  mepr_pkg::lane_hit_t [LANES-1:0] lane_hit;
  logic [LANES-1:0][VB-1:0]        lane_start;
  logic [LANES-1:0][VB-1:0]        lane_end;
  logic [LANES-1:0][VB-1:0]        lane_apex;
  mepr_pkg::find_t                 find;
  logic [LANE_W-1:0]               m_lane;
  logic [BANK_AW-1:0]              m_addr;
  logic [VB-1:0]                   m_start;
  logic [VB-1:0]                   m_end;
  logic [VB-1:0]                   m_apex;
  logic [LANE_W-1:0]               f_lane;
  logic [BANK_AW-1:0]              f_addr;

  // --------------------------------------------------------------------------
  // Handshake and status terms
  // --------------------------------------------------------------------------
  assign in_acc    = in_tri.valid && in_ready;
  assign cnt_last  = (cnt_r == BANK_AW'(BANK_DEPTH - 1));
  assign out_free  = !out_valid_r || out_res.ready;
  assign pipe_idle = !rd_v_r && !cmp_v_r;
  assign new_res   = find.match_found || !find.free_found;
  // A result can only move into the pending slot when the slot can be emptied.
  assign res_go    = (state_r == mepr_pkg::ST_RESOLVE) &&
                     (!new_res || !pend_v_r || out_free);
  assign flush_go  = (state_r == mepr_pkg::ST_FLUSH) && (!pend_v_r || out_free);
  assign out_ld    = (res_go && new_res && pend_v_r) || (flush_go && pend_v_r);

  always_comb begin
    case (edge_r)
      mepr_pkg::EDGE_AB: begin
        q_s = a_r; q_e = b_r; q_apex = c_r;
      end
      mepr_pkg::EDGE_BC: begin
        q_s = b_r; q_e = c_r; q_apex = a_r;
      end
      mepr_pkg::EDGE_CA: begin
        q_s = c_r; q_e = a_r; q_apex = b_r;
      end
      default: begin
        q_s = a_r; q_e = b_r; q_apex = c_r;
      end
    endcase
  end

  always_comb begin
    if (find.match_found) begin
      res_kind = mepr_pkg::KIND_PAIR;
      res_ap1  = m_apex;
      res_ap2  = q_apex;
      res_s    = m_start;
      res_e    = m_end;
    end else begin
      res_kind = mepr_pkg::KIND_OVERFLOW;
      res_ap1  = q_apex;
      res_ap2  = '0;
      res_s    = q_s;
      res_e    = q_e;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mepr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tri.first_triangle ? mepr_pkg::ST_CLEAR : mepr_pkg::ST_SCAN;
        end
      end
      mepr_pkg::ST_CLEAR: begin
        if (cnt_last) begin
          state_nxt = clr_scan_r ? mepr_pkg::ST_SCAN : mepr_pkg::ST_IDLE;
        end
      end
      mepr_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = mepr_pkg::ST_DRAIN;
        end
      end
      mepr_pkg::ST_DRAIN: begin
        if (pipe_idle) begin
          state_nxt = mepr_pkg::ST_RESOLVE;
        end
      end
      mepr_pkg::ST_RESOLVE: begin
        if (res_go) begin
          state_nxt = (edge_r == mepr_pkg::EDGE_CA) ? mepr_pkg::ST_FLUSH
                                                    : mepr_pkg::ST_SCAN;
        end
      end
      mepr_pkg::ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = mepr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mepr_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    issue_v  = 1'b0;
    lane_we  = '0;
    wr_addr  = cnt_r;
    wr_data  = '0;
    case (state_r)
      mepr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      mepr_pkg::ST_CLEAR: begin
        lane_we = '1;
      end
      mepr_pkg::ST_SCAN: begin
        issue_v = 1'b1;
      end
      mepr_pkg::ST_RESOLVE: begin
        if (res_go) begin
          if (find.match_found) begin
            lane_we[m_lane] = 1'b1;
            wr_addr         = m_addr;
            wr_data         = {1'b0, m_start, m_end, m_apex};
          end else if (find.free_found) begin
            lane_we[f_lane] = 1'b1;
            wr_addr         = f_addr;
            wr_data         = {1'b1, q_s, q_e, q_apex};
          end
        end
      end
      default: ;
    endcase
  end

  assign merge_clr = issue_v && (cnt_r == '0);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mepr_pkg::ST_CLEAR;
      cnt_r       <= '0;
      clr_scan_r  <= 1'b0;
      edge_r      <= mepr_pkg::EDGE_AB;
      rd_v_r      <= 1'b0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue_v;
      cmp_v_r <= rd_v_r;
      if ((state_r == mepr_pkg::ST_CLEAR) || (state_r == mepr_pkg::ST_SCAN)) begin
        cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (in_acc) begin
        clr_scan_r <= 1'b1;
        edge_r     <= mepr_pkg::EDGE_AB;
      end else if (res_go) begin
        case (edge_r)
          mepr_pkg::EDGE_AB: edge_r <= mepr_pkg::EDGE_BC;
          mepr_pkg::EDGE_BC: edge_r <= mepr_pkg::EDGE_CA;
          default:           edge_r <= edge_r;
        endcase
      end
      if (res_go && new_res) begin
        pend_v_r <= 1'b1;
      end else if (flush_go) begin
        pend_v_r <= 1'b0;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_row_r  <= cnt_r;
    cmp_row_r <= rd_row_r;
    if (in_acc) begin
      a_r <= in_tri.corner_a;
      b_r <= in_tri.corner_b;
      c_r <= in_tri.corner_c;
    end
    if (res_go && new_res) begin
      pend_kind_r <= res_kind;
      pend_ap1_r  <= res_ap1;
      pend_ap2_r  <= res_ap2;
      pend_s_r    <= res_s;
      pend_e_r    <= res_e;
    end
    if (out_ld) begin
      out_kind_r <= pend_kind_r;
      out_ap1_r  <= pend_ap1_r;
      out_ap2_r  <= pend_ap2_r;
      out_s_r    <= pend_s_r;
      out_e_r    <= pend_e_r;
      // Only the flush of the final pending result marks the end of a triangle.
      out_last_r <= (state_r == mepr_pkg::ST_FLUSH);
    end
  end

  // --------------------------------------------------------------------------
  // Lanes and merge
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mepr_lane #(
      .VB    (VB),
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_lane (
      .clk       (clk),
      .rd_en     (issue_v),
      .rd_addr   (cnt_r),
      .wr_en     (lane_we[g]),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .q_start   (q_s),
      .q_end     (q_e),
      .hit       (lane_hit[g]),
      .hit_start (lane_start[g]),
      .hit_end   (lane_end[g]),
      .hit_apex  (lane_apex[g])
    );
  end

  mepr_merge #(
    .LANES (LANES),
    .VB    (VB),
    .AW    (BANK_AW),
    .LW    (LANE_W)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (merge_clr),
    .en          (cmp_v_r),
    .row         (cmp_row_r),
    .hits        (lane_hit),
    .lane_start  (lane_start),
    .lane_end    (lane_end),
    .lane_apex   (lane_apex),
    .find        (find),
    .match_lane  (m_lane),
    .match_addr  (m_addr),
    .match_start (m_start),
    .match_end   (m_end),
    .match_apex  (m_apex),
    .free_lane   (f_lane),
    .free_addr   (f_addr)
  );

  assign in_tri.ready        = in_ready;
  assign out_res.valid       = out_valid_r;
  assign out_res.kind        = out_kind_r;
  assign out_res.apex_first  = out_ap1_r;
  assign out_res.apex_second = out_ap2_r;
  assign out_res.edge_start  = out_s_r;
  assign out_res.edge_end    = out_e_r;
  assign out_res.last        = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("pending result left over when a new triangle is taken");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mepr_pkg::ST_RESOLVE) |-> (!rd_v_r && !cmp_v_r))
    else $error("entry resolved before the lane pipeline drained");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mepr_pkg::ST_CLEAR) |-> $onehot0(lane_we))
    else $error("more than one lane written outside the clearing pass");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_v_r || cmp_v_r) |-> (lane_we == '0))
    else $error("table written while a scan is in flight");

endmodule

// File: tb/mepr_pair_checker.sv
// ----------------------------------------------------------------------------
// mepr_pair_checker
// Watches the triangle and result channels of the edge pairing core. It keeps
// its own copy of the pending-edge table and works out, for every accepted
// triangle request, the dihedral and overflow results it must cause. Each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mepr_pair_checker #(
  parameter int TABLE_DEPTH = 256,
  parameter int VERTEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mepr_in_if          tri_mon,
  mepr_out_if         res_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef logic [VERTEX_BITS-1:0] vtx_t;

  typedef struct packed {
    logic kind;
    vtx_t apex_first;
    vtx_t apex_second;
    vtx_t edge_start;
    vtx_t edge_end;
    logic last;
  } pair_res_t;

  logic        held_valid [TABLE_DEPTH];
  vtx_t        held_start [TABLE_DEPTH];
  vtx_t        held_end   [TABLE_DEPTH];
  vtx_t        held_apex  [TABLE_DEPTH];
  pair_res_t   dihedral_q[$];
  int unsigned err_cnt = 0;
  int unsigned res_seen = 0;

  assign mismatches = err_cnt;

  task automatic report_mismatch(input string what);
    $display("ERROR: result %0d: %s", res_seen, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // One edge against the table: lowest matching entry wins, else the lowest
  // free entry takes it, else it is dropped with an overflow result.
  task automatic pair_edge(input vtx_t s, input vtx_t e, input vtx_t apex,
                           inout int unsigned made);
    int unsigned free_idx;
    bit          have_free;
    pair_res_t   r;
    have_free = 1'b0;
    free_idx  = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (held_valid[i]) begin
        if ((held_start[i] == s && held_end[i] == e) ||
            (held_start[i] == e && held_end[i] == s)) begin
          r = '{kind: mepr_pkg::KIND_PAIR, apex_first: held_apex[i], apex_second: apex,
                edge_start: held_start[i], edge_end: held_end[i], last: 1'b0};
          dihedral_q.insert(dihedral_q.size(), r);
          held_valid[i] = 1'b0;
          made++;
          return;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
    end
    if (!have_free) begin
      r = '{kind: mepr_pkg::KIND_OVERFLOW, apex_first: apex, apex_second: '0,
            edge_start: s, edge_end: e, last: 1'b0};
      dihedral_q.insert(dihedral_q.size(), r);
      made++;
    end else begin
      held_valid[free_idx] = 1'b1;
      held_start[free_idx] = s;
      held_end[free_idx]   = e;
      held_apex[free_idx]  = apex;
    end
  endtask

  task automatic predict_triangle(input logic new_mesh, input vtx_t a,
                                  input vtx_t b, input vtx_t c);
    int unsigned made;
    made = 0;
    if (new_mesh)
      for (int i = 0; i < TABLE_DEPTH; i++) held_valid[i] = 1'b0;
    pair_edge(a, b, c, made);
    pair_edge(b, c, a, made);
    pair_edge(c, a, b, made);
    if (made > 0) dihedral_q[dihedral_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_result();
    pair_res_t want;
    if (dihedral_q.size() == 0) begin
      report_mismatch("result with nothing expected");
    end else begin
      want = dihedral_q.pop_front();
      check_field("kind", 32'(res_mon.kind), 32'(want.kind));
      check_field("apex_first", 32'(res_mon.apex_first), 32'(want.apex_first));
      check_field("apex_second", 32'(res_mon.apex_second), 32'(want.apex_second));
      check_field("edge_start", 32'(res_mon.edge_start), 32'(want.edge_start));
      check_field("edge_end", 32'(res_mon.edge_end), 32'(want.edge_end));
      check_field("last", 32'(res_mon.last), 32'(want.last));
    end
    res_seen++;
  endtask

  // Results are taken before requests: a result at this edge can never
  // belong to a triangle accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) held_valid[i] = 1'b0;
      dihedral_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (tri_mon.valid && tri_mon.ready)
        predict_triangle(tri_mon.first_triangle, tri_mon.corner_a,
                         tri_mon.corner_b, tri_mon.corner_c);
    end
    outstanding <= dihedral_q.size();
  end

endmodule

// File: tb/tb_mesh_edge_triangle_pairing_core.sv
// ----------------------------------------------------------------------------
// tb_mesh_edge_triangle_pairing_core
// Drives triangle requests into the edge pairing core: directed cases first
// (extreme indices, one to three pairings per triangle, repeated corners,
// mesh restarts), then random meshes built from shared edges, and a run that
// fills the table to force overflow. Both channels idle and stall at random.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mesh_edge_triangle_pairing_core;

  localparam int TABLE_DEPTH   = 256;
  localparam int VERTEX_BITS   = 16;
  localparam int LANES         = 8;
  localparam int ROWS          = TABLE_DEPTH / LANES;
  localparam int TRI_CYCLES    = 3 * ROWS + 14;
  localparam int SETTLE_CYCLES = 2 * (TRI_CYCLES + ROWS);
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HEAVY_PCT     = 69;
  localparam int LIGHT_PCT     = 9;
  localparam int FILL_TRIS     = 86;
  localparam int MESH_SEG_TRIS = 12;

  typedef logic [VERTEX_BITS-1:0] vtx_t;
  typedef enum int {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef struct {
    vtx_t s;
    vtx_t e;
  } side_t;

  logic        clk;
  logic        rst_n;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned outstanding;
  side_t       open_sides[$];
  vtx_t        recent_vtx[$];

  mepr_in_if  #(.VB(VERTEX_BITS)) tri_if ();
  mepr_out_if #(.VB(VERTEX_BITS)) res_if ();

  mesh_edge_triangle_pairing_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VERTEX_BITS(VERTEX_BITS),
    .LANES(LANES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tri(tri_if),
    .out_res(res_if)
  );

  mepr_pair_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VERTEX_BITS(VERTEX_BITS)
  ) pair_chk (
    .clk(clk),
    .rst_n(rst_n),
    .tri_mon(tri_if),
    .res_mon(res_if),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_cnt);
      $display("mesh_edge_triangle_pairing_core: mismatch");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        idle_pct = HEAVY_PCT;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct <= HEAVY_PCT;
      end
      IDLE_BOTH: begin
        idle_pct = LIGHT_PCT;
        stall_pct <= LIGHT_PCT;
      end
      default: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // Valid stays high from one request to the next unless an idle cycle is
  // drawn, so the line is never dropped and raised within one edge.
  task automatic send_tri(input logic new_mesh, input vtx_t a, input vtx_t b,
                          input vtx_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      tri_if.valid <= 1'b0;
      @(posedge clk);
    end
    tri_if.valid          <= 1'b1;
    tri_if.first_triangle <= new_mesh;
    tri_if.corner_a       <= a;
    tri_if.corner_b       <= b;
    tri_if.corner_c       <= c;
    @(posedge clk);
    while (!tri_if.ready) @(posedge clk);
  endtask

  function automatic vtx_t rand_vtx();
    return vtx_t'($urandom_range(0, (1 << VERTEX_BITS) - 1));
  endfunction

  // Mostly triangles that close an open edge of the current mesh, with an
  // apex often taken from recent vertices so that several edges close at once.
  task automatic random_mesh_tri();
    int unsigned pick;
    int unsigned roll;
    logic        new_mesh;
    vtx_t        s, e, v, a, b, c;
    side_t       sd;
    roll     = $urandom_range(0, 99);
    new_mesh = ($urandom_range(0, 99) < 8);
    if (new_mesh) open_sides.delete();
    if (roll < 75 && open_sides.size() > 0) begin
      pick = $urandom_range(0, open_sides.size() - 1);
      s = open_sides[pick].s;
      e = open_sides[pick].e;
      open_sides.delete(pick);
      if (recent_vtx.size() > 0 && $urandom_range(0, 1))
        v = recent_vtx[$urandom_range(0, recent_vtx.size() - 1)];
      else
        v = rand_vtx();
      if ($urandom_range(0, 4) == 0) {a, b, c} = {s, e, v};
      else {a, b, c} = {e, s, v};
      case ($urandom_range(0, 2))
        1: {a, b, c} = {b, c, a};
        2: {a, b, c} = {c, a, b};
        default: ;
      endcase
    end else begin
      a = rand_vtx();
      b = rand_vtx();
      c = rand_vtx();
      if (roll >= 90) begin
        case ($urandom_range(0, 2))
          0: b = a;
          1: c = b;
          default: a = c;
        endcase
      end
    end
    sd = '{a, b};
    open_sides.insert(open_sides.size(), sd);
    sd = '{b, c};
    open_sides.insert(open_sides.size(), sd);
    sd = '{c, a};
    open_sides.insert(open_sides.size(), sd);
    while (open_sides.size() > 48) void'(open_sides.pop_front());
    recent_vtx.insert(recent_vtx.size(), a);
    recent_vtx.insert(recent_vtx.size(), b);
    recent_vtx.insert(recent_vtx.size(), c);
    while (recent_vtx.size() > 9) void'(recent_vtx.pop_front());
    send_tri(new_mesh, a, b, c);
  endtask

  // Fills every entry with distinct edges, then mixes pairings against the
  // full table with edges that have nowhere to go.
  task automatic fill_and_overflow();
    vtx_t        base;
    int unsigned k;
    base = vtx_t'($urandom_range(0, (1 << VERTEX_BITS) - 3 * FILL_TRIS - 1));
    for (int i = 0; i < FILL_TRIS; i++) begin
      if (i % 24 == 0) set_idle(idle_mode_t'((i / 24) % 4));
      send_tri(i == 0, vtx_t'(base + 3 * i), vtx_t'(base + 3 * i + 1),
               vtx_t'(base + 3 * i + 2));
    end
    for (int j = 0; j < 10; j++) begin
      if (j % 3 == 0) set_idle(idle_mode_t'(j % 4));
      if (j < 6) begin
        k = $urandom_range(0, FILL_TRIS - 2);
        send_tri(1'b0, vtx_t'(base + 3 * k + 1), vtx_t'(base + 3 * k),
                 rand_vtx());
      end else begin
        send_tri(1'b0, rand_vtx(), rand_vtx(), rand_vtx());
      end
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    tri_if.valid          <= 1'b0;
    tri_if.first_triangle <= 1'b0;
    tri_if.corner_a       <= '0;
    tri_if.corner_b       <= '0;
    tri_if.corner_c       <= '0;
    set_idle(IDLE_OFF);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Simple pairing, then one edge shared in reverse order.
    send_tri(1'b1, 16'h0000, 16'h0001, 16'h0002);
    send_tri(1'b0, 16'h0001, 16'h0000, 16'h0003);
    // Extreme indices.
    send_tri(1'b1, 16'hFFFF, 16'h0000, 16'h8000);
    send_tri(1'b0, 16'h0000, 16'hFFFF, 16'h7FFF);
    send_tri(1'b0, 16'h8000, 16'hFFFF, 16'hAAAA);
    send_tri(1'b0, 16'h5555, 16'hAAAA, 16'h8000);
    // A triangle whose edges all close against the previous one.
    send_tri(1'b1, 16'h0010, 16'h0020, 16'h0030);
    send_tri(1'b0, 16'h0020, 16'h0010, 16'h0030);
    // Repeated corners pair with edges of their own triangle.
    send_tri(1'b1, 16'h0005, 16'h0005, 16'h0005);
    send_tri(1'b0, 16'h0007, 16'h0007, 16'h0009);
    send_tri(1'b0, 16'h0005, 16'h0005, 16'h0006);
    // Same orientation still pairs; a third triangle on a freed edge stores.
    send_tri(1'b0, 16'h0040, 16'h0041, 16'h0042);
    send_tri(1'b0, 16'h0040, 16'h0041, 16'h0043);
    send_tri(1'b0, 16'h0041, 16'h0040, 16'h0044);
    // A new mesh hides pending edges of the old one.
    send_tri(1'b1, 16'h0100, 16'h0101, 16'h0102);
    send_tri(1'b1, 16'h0101, 16'h0100, 16'h0103);
    send_tri(1'b0, 16'h0100, 16'h0101, 16'h0104);

    for (int seg = 0; seg < 4; seg++) begin
      set_idle(idle_mode_t'(seg));
      for (int i = 0; i < MESH_SEG_TRIS; i++) random_mesh_tri();
    end

    fill_and_overflow();
    tri_if.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mesh_edge_triangle_pairing_core: match");
    end else begin
      $display("mesh_edge_triangle_pairing_core: mismatch");
    end
    $finish;
  end

endmodule
